[src/rmst_pkg.sv]
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range-minimum segment tree: value type,
// the INF sentinel, operation codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

	typedef logic signed [31:0] value_t;

	// Largest signed value; marks an empty node or an empty range
	localparam value_t INF = 32'sh7FFF_FFFF;

	// Operation codes on the func field
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Node memory port enables
	typedef struct packed {
		logic we;
		logic re_a;
		logic re_b;
	} mem_ctl_t;

	// One query result
	typedef struct packed {
		value_t minimum;
		logic   range_empty;
	} result_t;

endpackage

`default_nettype wire

[src/rmst_cmd_if.sv]
// ----------------------------------------------------------------------------
// rmst_cmd_if
// Command channel: point write or range query, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmst_cmd_if;
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [9:0]           position;
	logic [10:0]          range_end;
	rmst_pkg::value_t     new_value;

	modport source (output valid, func, position, range_end, new_value, input ready);
	modport sink (input valid, func, position, range_end, new_value, output ready);
endinterface

`default_nettype wire

[src/rmst_res_if.sv]
// ----------------------------------------------------------------------------
// rmst_res_if
// Result channel: range minimum and empty flag, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmst_res_if;
	logic                 valid;
	logic                 ready;
	rmst_pkg::value_t     minimum;
	logic                 range_empty;

	modport source (output valid, minimum, range_empty, input ready);
	modport sink (input valid, minimum, range_empty, output ready);
endinterface

`default_nettype wire

[src/range_min_segment_tree.sv]
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Segment tree of signed 32-bit minimums over LEAVES leaves, held in one node
// memory. Takes point writes and half-open range minimum queries.
//
//   port   role     payload
//   cmd    sink     func, position, range_end, new_value
//   res    source   minimum, range_empty (one per query, none per write)
//
// A write holds the command port until it has climbed from the leaf to the root;
// each step reads the sibling and writes the parent.
// In a query walk the two read ports fetch both edge nodes of one level per
// cycle.
// After reset a clearing pass fills all 2*LEAVES nodes with INF, one per
// cycle, before the first command is taken.
// A result waits in the output register; writes proceed behind it, and a
// query stalls at its end until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module range_min_segment_tree #(
	parameter int LEAVES = 1024
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rmst_cmd_if.sink    cmd,
	rmst_res_if.source  res
);
	import rmst_pkg::*;

	localparam int DEPTH = 2 * LEAVES;
	localparam int AW    = $clog2(DEPTH);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	value_t        wdata;
	value_t        rdata_a;
	value_t        rdata_b;
	logic          res_free;
	logic          res_load;
	result_t       res_data;
	logic          out_valid_q;
	result_t       out_q;

	rmst_walk #(
		.LEAVES (LEAVES)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res_free (res_free),
		.res_load (res_load),
		.res_data (res_data),
		.mem_ctl  (mem_ctl),
		.waddr    (waddr),
		.wdata    (wdata),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b)
	);

	rmst_node_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Output register: free when empty or being taken this cycle
	assign res_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
				out_q       <= res_data;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.minimum     = out_q.minimum;
	assign res.range_empty = out_q.range_empty;

endmodule

`default_nettype wire

[src/rmst_node_mem.sv]
// ----------------------------------------------------------------------------
// rmst_node_mem
// Tree node storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_node_mem #(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire rmst_pkg::mem_ctl_t ctl,
	input  wire logic [AW-1:0]      waddr,
	input  wire rmst_pkg::value_t   wdata,
	input  wire logic [AW-1:0]      raddr_a,
	input  wire logic [AW-1:0]      raddr_b,
	output rmst_pkg::value_t        rdata_a,
	output rmst_pkg::value_t        rdata_b
);
	import rmst_pkg::*;

	value_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, registered read data
	always_ff @(posedge clk) begin
		if (ctl.re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (ctl.re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

[src/rmst_walk.sv]
// ----------------------------------------------------------------------------
// rmst_walk
// Tree walk sequencer: clears the node memory after reset, climbs from a leaf
// to the root on a write, and folds node minimums level by level on a query.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_walk #(
	parameter int LEAVES = 1024,
	localparam int AW = $clog2(LEAVES) + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	rmst_cmd_if.sink                cmd,
	input  wire logic               res_free,
	output logic                    res_load,
	output rmst_pkg::result_t       res_data,
	output rmst_pkg::mem_ctl_t      mem_ctl,
	output logic [AW-1:0]           waddr,
	output rmst_pkg::value_t        wdata,
	output logic [AW-1:0]           raddr_a,
	output logic [AW-1:0]           raddr_b,
	input  wire rmst_pkg::value_t   rdata_a,
	input  wire rmst_pkg::value_t   rdata_b
);
	import rmst_pkg::*;

	localparam int LW = $clog2(LEAVES);
	localparam int IW = LW + 2;
	localparam int CW = (IW > 11) ? IW : 11;
	localparam logic [CW-1:0] LEAVES_C  = CW'(LEAVES);
	localparam logic [AW-1:0] LAST_NODE = AW'(2 * LEAVES - 1);
	localparam logic [AW-1:0] ROOT      = AW'(1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WUP   = 3'd2;
	localparam logic [2:0] ST_QWALK = 3'd3;
	localparam logic [2:0] ST_QOUT  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] node_q;
	value_t        cur_q;
	logic [IW-1:0] l_q;
	logic [IW-1:0] r_q;
	logic          va_q;
	logic          vb_q;
	value_t        best_q;
	logic          empty_q;

	logic [CW-1:0] pos_w;
	logic [CW-1:0] end_w;
	logic [CW-1:0] lo_w;
	logic [CW-1:0] hi_w;
	logic [CW-1:0] leaf_w;
	logic [CW-1:0] l_init_w;
	logic [CW-1:0] r_init_w;
	logic [AW-1:0] leaf_node;
	logic          write_ok;
	logic          accept;
	logic [AW-1:0] parent;
	value_t        up_min;
	value_t        cand_a;
	value_t        cand_b;
	value_t        pair_min;
	value_t        best_n;
	logic          walk_on;
	logic [IW-1:0] l_next;
	logic [IW-1:0] r_dec;

	// Clip the command fields to the leaf range
	always_comb begin
		pos_w     = CW'(cmd.position);
		end_w     = CW'(cmd.range_end);
		lo_w      = (pos_w > LEAVES_C) ? LEAVES_C : pos_w;
		hi_w      = (end_w > LEAVES_C) ? LEAVES_C : end_w;
		leaf_w    = pos_w + LEAVES_C;
		l_init_w  = lo_w + LEAVES_C;
		r_init_w  = hi_w + LEAVES_C;
		leaf_node = leaf_w[AW-1:0];
		write_ok  = pos_w < LEAVES_C;
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// Climb step: combine the carried value with the sibling just read
	assign parent = {1'b0, node_q[AW-1:1]};
	assign up_min = (rdata_a < cur_q) ? rdata_a : cur_q;

	// Query step: fold the nodes read in the previous level
	always_comb begin
		cand_a   = va_q ? rdata_a : INF;
		cand_b   = vb_q ? rdata_b : INF;
		pair_min = (cand_a < cand_b) ? cand_a : cand_b;
		best_n   = (pair_min < best_q) ? pair_min : best_q;
		walk_on  = l_q < r_q;
		l_next   = l_q + IW'(l_q[0]);
		r_dec    = r_q - IW'(r_q[0]);
	end

	// Drive the node memory ports
	always_comb begin
		mem_ctl = '0;
		waddr   = clr_q;
		wdata   = INF;
		raddr_a = leaf_node ^ ROOT;
		raddr_b = r_dec[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_ctl.we = 1'b1;
			end
			ST_IDLE: begin
				if (accept && cmd.func == FUNC_WRITE && write_ok) begin
					mem_ctl.we   = 1'b1;
					mem_ctl.re_a = 1'b1;
					waddr        = leaf_node;
					wdata        = cmd.new_value;
				end
			end
			ST_WUP: begin
				mem_ctl.we   = 1'b1;
				waddr        = parent;
				wdata        = up_min;
				mem_ctl.re_a = (parent != ROOT);
				raddr_a      = parent ^ ROOT;
			end
			ST_QWALK: begin
				if (walk_on) begin
					mem_ctl.re_a = l_q[0];
					mem_ctl.re_b = r_q[0];
					raddr_a      = l_q[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Hand the result to the output register
	assign res_load = (state_q == ST_QOUT) && res_free;
	always_comb begin
		res_data.minimum     = best_q;
		res_data.range_empty = empty_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			node_q  <= '0;
			cur_q   <= INF;
			l_q     <= '0;
			r_q     <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
			best_q  <= INF;
			empty_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_NODE) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd.func == FUNC_WRITE) begin
							// drop writes beyond the leaves
							if (write_ok) begin
								node_q  <= leaf_node;
								cur_q   <= cmd.new_value;
								state_q <= ST_WUP;
							end
						end else begin
							l_q     <= l_init_w[IW-1:0];
							r_q     <= r_init_w[IW-1:0];
							empty_q <= (lo_w >= hi_w);
							best_q  <= INF;
							va_q    <= 1'b0;
							vb_q    <= 1'b0;
							state_q <= ST_QWALK;
						end
					end
				end
				ST_WUP: begin
					cur_q  <= up_min;
					node_q <= parent;
					if (parent == ROOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QWALK: begin
					best_q <= best_n;
					if (walk_on) begin
						l_q  <= l_next >> 1;
						r_q  <= r_dec >> 1;
						va_q <= l_q[0];
						vb_q <= r_q[0];
					end else begin
						va_q    <= 1'b0;
						vb_q    <= 1'b0;
						state_q <= ST_QOUT;
					end
				end
				ST_QOUT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[tb/rmst_min_check.sv]
// ----------------------------------------------------------------------------
// rmst_min_check
// Watches the command and result channels of the range-minimum segment tree.
// Keeps its own copy of the tree, updates it on every accepted write, works
// out the minimum and empty flag of every accepted query, and compares each
// accepted result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_min_check #(
	parameter int LEAVES = 1024
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rmst_cmd_if       cmd,
	rmst_res_if       res,
	output int        mismatches,
	output int        pending,
	output int        writes_seen,
	output int        queries_seen,
	output int        empties_seen
);
	import rmst_pkg::*;

	// Heap-ordered node copy: node 1 is the root, leaf p sits at LEAVES + p
	value_t  tree_mins [1:2*LEAVES-1];
	result_t query_results [$];
	int      n_bad;
	int      n_wr;
	int      n_qry;
	int      n_empty;

	// Store a leaf and refresh every ancestor up to the root
	function automatic void store_leaf(int unsigned pos, value_t val);
		int unsigned node;
		if (pos >= LEAVES)
			return;
		node = pos + LEAVES;
		tree_mins[node] = val;
		while (node > 1) begin
			node >>= 1;
			tree_mins[node] = (tree_mins[2*node] < tree_mins[2*node+1]) ?
				tree_mins[2*node] : tree_mins[2*node+1];
		end
	endfunction

	// Minimum over the half-open leaf range [lo, hi), bottom-up walk
	function automatic value_t range_min(int unsigned lo, int unsigned hi);
		value_t      best;
		int unsigned l;
		int unsigned r;
		best = INF;
		l = lo + LEAVES;
		r = hi + LEAVES;
		while (l < r) begin
			if (l[0]) begin
				if (tree_mins[l] < best)
					best = tree_mins[l];
				l++;
			end
			if (r[0]) begin
				r--;
				if (tree_mins[r] < best)
					best = tree_mins[r];
			end
			l >>= 1;
			r >>= 1;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t     seen;
		result_t     want;
		int unsigned lo;
		int unsigned hi;
		if (!arst_n) begin
			for (int n = 1; n < 2*LEAVES; n++)
				tree_mins[n] = INF;
			query_results.delete();
			n_bad   = 0;
			n_wr    = 0;
			n_qry   = 0;
			n_empty = 0;
		end else begin
			// Check results first: they belong to queries taken on earlier edges
			if (res.valid && res.ready) begin
				seen.minimum     = res.minimum;
				seen.range_empty = res.range_empty;
				if (query_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: unexpected result: minimum %0d empty %0b",
							$realtime, seen.minimum, seen.range_empty);
				end else begin
					want = query_results.pop_front();
					if (seen.minimum !== want.minimum ||
						seen.range_empty !== want.range_empty) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: result mismatch: minimum exp %0d got %0d, empty exp %0b got %0b",
								$realtime, want.minimum, seen.minimum,
								want.range_empty, seen.range_empty);
					end
				end
			end

			// Advance the tree on writes, predict the result of queries
			if (cmd.valid && cmd.ready) begin
				if (cmd.func == FUNC_WRITE) begin
					store_leaf(cmd.position, cmd.new_value);
					n_wr++;
				end else begin
					lo = (cmd.position > LEAVES) ? LEAVES : cmd.position;
					hi = (cmd.range_end > LEAVES) ? LEAVES : cmd.range_end;
					want.range_empty = (lo >= hi);
					want.minimum     = want.range_empty ? INF : range_min(lo, hi);
					query_results.push_back(want);
					n_qry++;
					if (want.range_empty)
						n_empty++;
				end
			end
		end
		mismatches   <= n_bad;
		pending      <= query_results.size();
		writes_seen  <= n_wr;
		queries_seen <= n_qry;
		empties_seen <= n_empty;
	end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the range-minimum segment tree. Drives a directed
// set of writes and queries over the edges of the leaf range and the value
// range, then a long random mix with random gaps on the command side and
// random stalls on the result side. Checking is done by rmst_min_check.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import rmst_pkg::*;

	localparam int     LEAVES  = 1024;
	localparam int     ITEMS   = 650;
	localparam value_t VAL_MIN = 32'sh8000_0000;

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet_phase;
	int   mismatches;
	int   pending;
	int   writes_seen;
	int   queries_seen;
	int   empties_seen;

	rmst_cmd_if cmd_ch ();
	rmst_res_if res_ch ();

	range_min_segment_tree #(.LEAVES(LEAVES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	rmst_min_check #(.LEAVES(LEAVES)) min_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.res          (res_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.writes_seen  (writes_seen),
		.queries_seen (queries_seen),
		.empties_seen (empties_seen)
	);

	always #5 clk = ~clk;

	// Idle cycles before the next transaction; none during a quiet phase
	function automatic int idle_cycles();
		if (quiet_phase)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	// Present one command after a random gap, hold it until accepted
	task automatic issue_cmd(logic f, logic [9:0] pos, logic [10:0] hi, value_t val);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.func      <= f;
		cmd_ch.position  <= pos;
		cmd_ch.range_end <= hi;
		cmd_ch.new_value <= val;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	// Result side: stall a random number of cycles, then take one transaction
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		forever begin
			stall = idle_cycles();
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_ch.valid);
		end
	end

	// Stimulus and verdict
	initial begin
		logic [9:0]  pos;
		logic [10:0] hi;
		value_t      val;
		arst_n           <= 1'b0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.func      <= FUNC_WRITE;
		cmd_ch.position  <= '0;
		cmd_ch.range_end <= '0;
		cmd_ch.new_value <= '0;
		quiet_phase = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh tree: every leaf INF, empty and clipped ranges
		issue_cmd(FUNC_QUERY, 10'd0, 11'd1024, '0);
		issue_cmd(FUNC_QUERY, 10'd5, 11'd5, '0);
		issue_cmd(FUNC_QUERY, 10'd10, 11'd3, '0);
		issue_cmd(FUNC_QUERY, 10'd0, 11'd0, '0);
		issue_cmd(FUNC_QUERY, 10'd1023, 11'd2047, '0);

		// Extremes of position and value
		issue_cmd(FUNC_WRITE, 10'd0, 11'd2047, VAL_MIN);
		issue_cmd(FUNC_WRITE, 10'd1023, 11'd0, INF);
		issue_cmd(FUNC_WRITE, 10'd512, 11'd0, 32'sd0);
		issue_cmd(FUNC_WRITE, 10'd511, 11'd0, -32'sd1);
		issue_cmd(FUNC_WRITE, 10'd1, 11'd1365, 32'sh5555_5555);
		issue_cmd(FUNC_WRITE, 10'd2, 11'd682, 32'shAAAA_AAAA);

		issue_cmd(FUNC_QUERY, 10'd0, 11'd1024, '0);
		issue_cmd(FUNC_QUERY, 10'd1, 11'd1024, '0);
		issue_cmd(FUNC_QUERY, 10'd1023, 11'd1024, '0);
		issue_cmd(FUNC_QUERY, 10'd1023, 11'd2047, '0);
		issue_cmd(FUNC_QUERY, 10'd511, 11'd513, '0);
		issue_cmd(FUNC_QUERY, 10'd2, 11'd3, '0);
		issue_cmd(FUNC_QUERY, 10'd0, 11'd1, '0);
		issue_cmd(FUNC_QUERY, 10'd3, 11'd511, '0);
		issue_cmd(FUNC_QUERY, 10'd513, 11'd1023, '0);

		// Overwrite the global minimum and check it moves
		issue_cmd(FUNC_WRITE, 10'd0, 11'd0, 32'sd7);
		issue_cmd(FUNC_QUERY, 10'd0, 11'd1024, 32'sh7FFF_FFFF);
		issue_cmd(FUNC_QUERY, 10'd0, 11'd2, '0);

		// Random mix of writes and queries
		for (int i = 0; i < ITEMS; i++) begin
			if (i % 50 == 0)
				quiet_phase = ($urandom_range(0, 3) == 0);

			case ($urandom_range(0, 3))
				0, 1:    pos = 10'($urandom_range(0, LEAVES - 1));
				2:       pos = 10'($urandom_range(0, 31));
				default: pos = 10'($urandom_range(LEAVES - 32, LEAVES - 1));
			endcase
			hi = 11'($urandom_range(0, 2047));
			case ($urandom_range(0, 7))
				0:       val = VAL_MIN;
				1:       val = INF;
				2:       val = $urandom_range(0, 200) - 100;
				default: val = $urandom;
			endcase

			if ($urandom_range(0, 99) < 45) begin
				issue_cmd(FUNC_WRITE, pos, hi, val);
			end else begin
				// Mostly ranges starting at pos, some empty, some fully random
				case ($urandom_range(0, 9))
					0:       hi = 11'(pos);
					1:       ;
					2, 3:    hi = 11'(pos + $urandom_range(1, 4));
					default: hi = 11'(pos + $urandom_range(1, 300));
				endcase
				issue_cmd(FUNC_QUERY, pos, hi, val);
			end
		end
		cmd_ch.valid <= 1'b0;

		// Drain outstanding results, then let the block settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d writes and %0d queries, %0d of them on empty ranges.",
			writes_seen, queries_seen, empties_seen);
		if (mismatches == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding.", pending);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

[range_min_segment_tree.f]
src/rmst_pkg.sv
src/rmst_cmd_if.sv
src/rmst_res_if.sv
src/rmst_node_mem.sv
src/rmst_walk.sv
src/range_min_segment_tree.sv
tb/rmst_min_check.sv
tb/testbench.sv
